[hdl/mtp_pkg.sv]
// Shared types, codes and helper functions of the management packet byte tagger.
`default_nettype none

package mtp_pkg;

  // Parse phases of one datagram.
  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_TYPE    = 4'd1,
    PH_SETHDR  = 4'd2,
    PH_TLVTYPE = 4'd3,
    PH_TLVLEN  = 4'd4,
    PH_VALUE   = 4'd5,
    PH_SETRES  = 4'd6,
    PH_TRAILER = 4'd7,
    PH_RAW     = 4'd8,
    PH_SURPLUS = 4'd9,
    PH_REJECT  = 4'd10
  } phase_t;

  // Role tag given to each byte.
  typedef enum logic [3:0] {
    ROLE_MAGIC     = 4'd0,
    ROLE_TYPE      = 4'd1,
    ROLE_SETLEN    = 4'd2,
    ROLE_SALT      = 4'd3,
    ROLE_AUTH      = 4'd4,
    ROLE_TLVTYPE   = 4'd5,
    ROLE_TLVLEN    = 4'd6,
    ROLE_VALUE     = 4'd7,
    ROLE_END       = 4'd8,
    ROLE_GETALL    = 4'd9,
    ROLE_SETRESULT = 4'd10,
    ROLE_TRAILER   = 4'd11,
    ROLE_RAW       = 4'd12,
    ROLE_SURPLUS   = 4'd13,
    ROLE_REJECTED  = 4'd14
  } role_t;

  // Packet type codes.
  localparam logic [7:0] KIND_QRESP  = 8'h02;
  localparam logic [7:0] KIND_SET    = 8'h07;
  localparam logic [7:0] KIND_SETRES = 8'h08;
  localparam logic [7:0] KIND_GET    = 8'h0b;
  localparam logic [7:0] KIND_GRESP  = 8'h0c;

  // Special TLV type codes.
  localparam logic [7:0] TLV_END    = 8'hff;
  localparam logic [7:0] TLV_GETALL = 8'h63;

  // Header offsets.
  localparam logic [4:0] MAGIC_LEN    = 5'd5;
  localparam logic [4:0] SETHDR_START = 5'd6;
  localparam logic [4:0] SALT_START   = 5'd8;
  localparam logic [4:0] AUTH_START   = 5'd12;
  localparam logic [4:0] SETHDR_STOP  = 5'd28;

  // Magic characters; letters compare with the case bit forced on.
  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [7:0] MAGIC_N   = 8'h6e;
  localparam logic [7:0] MAGIC_J   = 8'h6a;
  localparam logic [7:0] MAGIC_TWO = 8'h32;
  localparam logic [7:0] MAGIC_ZERO = 8'h30;

  // Parser state carried from byte to byte.
  typedef struct packed {
    logic [4:0] position;
    phase_t     phase;
    logic [7:0] kind;
    logic [7:0] tlv_code;
    logic [7:0] tlv_size;
    logic [7:0] left;
  } state_t;

  localparam state_t STATE_RESET = '{
    position: 5'd0,
    phase:    PH_MAGIC,
    kind:     8'd0,
    tlv_code: 8'd0,
    tlv_size: 8'd0,
    left:     8'd0
  };

  // Tag result of one byte.
  typedef struct packed {
    role_t      role;
    logic [7:0] kind;
    logic [7:0] tlv_code;
    logic [7:0] tlv_size;
    logic       malformed;
    logic       rejected;
    logic       frame_end;
  } result_t;

  // Check one magic byte against its offset.
  function automatic logic magic_ok(input logic [4:0] pos, input logic [7:0] b);
    logic ok;
    case (pos)
      5'd0:    ok = ((b | CASE_BIT) == MAGIC_N);
      5'd1:    ok = ((b | CASE_BIT) == MAGIC_J);
      5'd2:    ok = (b == MAGIC_TWO);
      5'd3:    ok = (b == MAGIC_ZERO);
      5'd4:    ok = (b == MAGIC_ZERO);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Number of value bytes of a TLV, fixed by type or taken from its length byte.
  function automatic logic [7:0] value_count(input logic [7:0] t, input logic [7:0] len);
    logic [7:0] n;
    case (t)
      8'h00: n = 8'd0;
      8'h05, 8'h06, 8'h0a, 8'h0b, 8'h0c, 8'h1a, 8'h1e, 8'h1f: n = 8'd1;
      8'h02, 8'h03, 8'h04, 8'h0f, 8'h20: n = 8'd4;
      8'h01: n = 8'd6;
      default: n = len;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[hdl/mtp_classify.sv]
// Combinational byte classifier: next parser state and tag of one byte.
`default_nettype none

module mtp_classify (
  input  mtp_pkg::state_t  state,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output mtp_pkg::state_t  state_next,
  output mtp_pkg::result_t result
);

  always_comb begin
    mtp_pkg::state_t s;
    mtp_pkg::role_t  role;
    logic [7:0]      ttype;
    logic [7:0]      tlen;
    logic [7:0]      n;
    logic [7:0]      left_dec;
    logic [4:0]      pos_inc;
    logic            rej;

    s        = state;
    role     = mtp_pkg::ROLE_REJECTED;
    ttype    = 8'd0;
    tlen     = 8'd0;
    rej      = 1'b0;
    n        = mtp_pkg::value_count(state.tlv_code, data_byte);
    pos_inc  = state.position + 5'd1;
    left_dec = (state.left != 8'd0) ? state.left - 8'd1 : state.left;

    // Phase dispatch for one byte.
    case (state.phase)
      mtp_pkg::PH_MAGIC: begin
        if (!mtp_pkg::magic_ok(state.position, data_byte) || last_byte) begin
          rej     = 1'b1;
          s.phase = mtp_pkg::PH_REJECT;
        end else begin
          role       = mtp_pkg::ROLE_MAGIC;
          s.position = pos_inc;
          if (pos_inc >= mtp_pkg::MAGIC_LEN) begin
            s.phase = mtp_pkg::PH_TYPE;
          end
        end
      end
      mtp_pkg::PH_TYPE: begin
        role   = mtp_pkg::ROLE_TYPE;
        s.kind = data_byte;
        if (data_byte == mtp_pkg::KIND_SET) begin
          s.phase    = mtp_pkg::PH_SETHDR;
          s.position = mtp_pkg::SETHDR_START;
        end else if (data_byte == mtp_pkg::KIND_SETRES) begin
          s.phase = mtp_pkg::PH_SETRES;
        end else if (data_byte == mtp_pkg::KIND_GET || data_byte == mtp_pkg::KIND_QRESP ||
                     data_byte == mtp_pkg::KIND_GRESP) begin
          s.phase = mtp_pkg::PH_TLVTYPE;
        end else begin
          s.phase = mtp_pkg::PH_RAW;
        end
      end
      mtp_pkg::PH_SETHDR: begin
        if (state.position < mtp_pkg::SALT_START) begin
          role = mtp_pkg::ROLE_SETLEN;
        end else if (state.position < mtp_pkg::AUTH_START) begin
          role = mtp_pkg::ROLE_SALT;
        end else begin
          role = mtp_pkg::ROLE_AUTH;
        end
        s.position = pos_inc;
        if (pos_inc >= mtp_pkg::SETHDR_STOP || pos_inc < mtp_pkg::SETHDR_START) begin
          s.phase = mtp_pkg::PH_TLVTYPE;
        end
      end
      mtp_pkg::PH_TLVTYPE: begin
        s.tlv_code = data_byte;
        ttype      = data_byte;
        if (data_byte == mtp_pkg::TLV_END) begin
          role = mtp_pkg::ROLE_END;
          if (state.kind == mtp_pkg::KIND_QRESP || state.kind == mtp_pkg::KIND_GRESP) begin
            s.phase = mtp_pkg::PH_TRAILER;
          end else begin
            s.phase = mtp_pkg::PH_SURPLUS;
          end
        end else if (data_byte == mtp_pkg::TLV_GETALL) begin
          role = mtp_pkg::ROLE_GETALL;
        end else begin
          role    = mtp_pkg::ROLE_TLVTYPE;
          s.phase = mtp_pkg::PH_TLVLEN;
        end
      end
      mtp_pkg::PH_TLVLEN: begin
        role       = mtp_pkg::ROLE_TLVLEN;
        ttype      = state.tlv_code;
        tlen       = data_byte;
        s.tlv_size = data_byte;
        s.left     = n;
        s.phase    = (n == 8'd0) ? mtp_pkg::PH_TLVTYPE : mtp_pkg::PH_VALUE;
      end
      mtp_pkg::PH_VALUE: begin
        role   = mtp_pkg::ROLE_VALUE;
        ttype  = state.tlv_code;
        tlen   = state.tlv_size;
        s.left = left_dec;
        if (left_dec == 8'd0) begin
          s.phase = mtp_pkg::PH_TLVTYPE;
        end
      end
      mtp_pkg::PH_SETRES: begin
        role    = mtp_pkg::ROLE_SETRESULT;
        s.phase = mtp_pkg::PH_SURPLUS;
      end
      mtp_pkg::PH_TRAILER: begin
        role    = mtp_pkg::ROLE_TRAILER;
        s.phase = mtp_pkg::PH_SURPLUS;
      end
      mtp_pkg::PH_RAW: begin
        role = mtp_pkg::ROLE_RAW;
      end
      mtp_pkg::PH_SURPLUS: begin
        role = mtp_pkg::ROLE_SURPLUS;
      end
      default: begin
        // Rejected datagrams and meaningless phases tag every byte as rejected.
        rej     = 1'b1;
        s.phase = mtp_pkg::PH_REJECT;
      end
    endcase

    // Build the tag from the updated state.
    result.role      = role;
    result.kind      = rej ? 8'd0 : s.kind;
    result.tlv_code  = ttype;
    result.tlv_size  = tlen;
    result.malformed = last_byte && !rej && s.phase != mtp_pkg::PH_RAW &&
                       s.phase != mtp_pkg::PH_SURPLUS;
    result.rejected  = rej;
    result.frame_end = last_byte;

    // The final byte of a datagram returns the parser to its start.
    state_next = last_byte ? mtp_pkg::STATE_RESET : s;
  end

endmodule

`default_nettype wire

[hdl/mgmt_tlv_packet_parser.sv]
// Top level of the management packet byte tagger: handshake, state and result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in      | input     | in_valid / in_ready   | data_byte, last_byte
//   out     | output    | out_valid / out_ready | byte_role, packet_kind, current_tlv_type,
//           |           |                       | current_tlv_length, malformed, rejected,
//           |           |                       | frame_end
//
// Each request is classified combinationally; its tag appears in the result register on
// the next cycle, and a new byte is taken every cycle while the output is drained.
// The result register decouples the sides: in_ready is low only while a tag waits.
// Reset (rst, synchronous) returns the parser to the magic phase and empties the output.
// A byte marked last_byte also returns the parser to the magic phase.
`default_nettype none

module mgmt_tlv_packet_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] byte_role,
  output logic [7:0] packet_kind,
  output logic [7:0] current_tlv_type,
  output logic [7:0] current_tlv_length,
  output logic       malformed,
  output logic       rejected,
  output logic       frame_end
);

  mtp_pkg::state_t  state;
  mtp_pkg::state_t  state_next;
  mtp_pkg::result_t result;
  mtp_pkg::result_t result_next;
  logic             in_accept;

  // Accept when the result register is empty or being emptied this cycle.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  mtp_classify u_classify (
    .state      (state),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .state_next (state_next),
    .result     (result_next)
  );

  // Parser state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtp_pkg::STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      result <= result_next;
    end
  end

  assign byte_role          = result.role;
  assign packet_kind        = result.kind;
  assign current_tlv_type   = result.tlv_code;
  assign current_tlv_length = result.tlv_size;
  assign malformed          = result.malformed;
  assign rejected           = result.rejected;
  assign frame_end          = result.frame_end;

endmodule

`default_nettype wire
